// ===== rtl/ale_pkg.sv =====
// ----------------------------------------------------------------------------
// ale_pkg
// Types, degree/order codes and per-formula constants for the Legendre unit.
// ----------------------------------------------------------------------------
package ale_pkg;

	localparam int NST = 22;

	// {degree, |order|} codes
	localparam logic [6:0] LM_00 = {3'd0, 4'd0};
	localparam logic [6:0] LM_10 = {3'd1, 4'd0};
	localparam logic [6:0] LM_11 = {3'd1, 4'd1};
	localparam logic [6:0] LM_20 = {3'd2, 4'd0};
	localparam logic [6:0] LM_21 = {3'd2, 4'd1};
	localparam logic [6:0] LM_22 = {3'd2, 4'd2};
	localparam logic [6:0] LM_30 = {3'd3, 4'd0};
	localparam logic [6:0] LM_31 = {3'd3, 4'd1};
	localparam logic [6:0] LM_32 = {3'd3, 4'd2};
	localparam logic [6:0] LM_33 = {3'd3, 4'd3};
	localparam logic [6:0] LM_40 = {3'd4, 4'd0};
	localparam logic [6:0] LM_41 = {3'd4, 4'd1};
	localparam logic [6:0] LM_42 = {3'd4, 4'd2};
	localparam logic [6:0] LM_43 = {3'd4, 4'd3};
	localparam logic [6:0] LM_44 = {3'd4, 4'd4};
	localparam logic [6:0] LM_50 = {3'd5, 4'd0};

	typedef struct packed {
		logic signed [16:0] x;
		logic [2:0]         l;
		logic [3:0]         am;
		logic               neg;
		logic               bad;
		logic [28:0]        u;
		logic [28:0]        s;
		logic [29:0]        sv;
		logic [29:0]        rs;
		logic signed [31:0] tt;
		logic signed [35:0] lin;
		logic signed [50:0] pl;
		logic signed [49:0] ph;
		logic signed [63:0] pp;
		logic signed [71:0] nn;
		logic               nsg;
		logic [71:0]        mh;
		logic signed [49:0] vv;
		logic signed [42:0] xl;
		logic signed [41:0] xh;
		logic signed [67:0] xn;
		logic [67:0]        mh5;
		logic [25:0]        n2;
		logic [24:0]        q0;
		logic [42:0]        qd;
		logic [24:0]        qq;
		logic [23:0]        val;
	} pipe_t;

	// linear term c1*u + c0 (Q28)
	function automatic logic signed [35:0] lin_of(input logic [2:0] l, input logic [3:0] am,
			input logic [28:0] u);
		logic signed [36:0] us;
		logic signed [36:0] one;
		logic signed [36:0] t;
		us  = $signed({8'd0, u});
		one = 37'sd268435456;
		t   = '0;
		unique case ({l, am})
			LM_20:   t = 37'sd3 * us - one;
			LM_30:   t = 37'sd5 * us - 37'sd3 * one;
			LM_31:   t = 37'sd3 * one - 37'sd15 * us;
			LM_40:   t = 37'sd35 * us - 37'sd30 * one;
			LM_41:   t = 37'sd15 * one - 37'sd35 * us;
			LM_42:   t = 37'sd105 * us - 37'sd15 * one;
			LM_50:   t = 37'sd63 * us - 37'sd70 * one;
			default: t = '0;
		endcase
		return t[35:0];
	endfunction

	function automatic logic signed [7:0] c_of(input logic [2:0] l, input logic [3:0] am);
		unique case ({l, am})
			LM_10:   return 8'sd4;
			LM_11:   return -8'sd4;
			LM_21:   return -8'sd3;
			LM_22:   return 8'sd3;
			LM_32:   return 8'sd15;
			LM_33:   return -8'sd15;
			LM_43:   return -8'sd105;
			LM_44:   return 8'sd105;
			LM_20, LM_30, LM_31, LM_40, LM_41, LM_42, LM_50: return 8'sd1;
			default: return 8'sd0;
		endcase
	endfunction

	function automatic logic signed [71:0] k_of(input logic [2:0] l, input logic [3:0] am);
		unique case ({l, am})
			LM_00:   return 72'sd65536;
			LM_40:   return 72'sd3 <<< 56;
			LM_50:   return 72'sd15 <<< 56;
			default: return '0;
		endcase
	endfunction

	function automatic logic [5:0] sh_of(input logic [2:0] l, input logic [3:0] am);
		unique case ({l, am})
			LM_20:          return 6'd13;
			LM_21, LM_22:   return 6'd12;
			LM_30, LM_31:   return 6'd27;
			LM_32, LM_33:   return 6'd26;
			LM_40:          return 6'd43;
			LM_41, LM_42:   return 6'd41;
			LM_43, LM_44:   return 6'd40;
			LM_50:          return 6'd14;
			default:        return 6'd0;
		endcase
	endfunction

	// (l+m)!/(l-m)!
	function automatic logic [16:0] den_of(input logic [2:0] l, input logic [3:0] am);
		unique case ({l, am})
			LM_11:   return 17'd2;
			LM_21:   return 17'd6;
			LM_22:   return 17'd24;
			LM_31:   return 17'd12;
			LM_32:   return 17'd120;
			LM_33:   return 17'd720;
			LM_41:   return 17'd20;
			LM_42:   return 17'd360;
			LM_43:   return 17'd5040;
			LM_44:   return 17'd40320;
			default: return 17'd1;
		endcase
	endfunction

	// floor(2^27 / (2*den))
	function automatic logic [25:0] rcp_of(input logic [2:0] l, input logic [3:0] am);
		unique case ({l, am})
			LM_11:   return 26'((1 << 27) / 4);
			LM_21:   return 26'((1 << 27) / 12);
			LM_22:   return 26'((1 << 27) / 48);
			LM_31:   return 26'((1 << 27) / 24);
			LM_32:   return 26'((1 << 27) / 240);
			LM_33:   return 26'((1 << 27) / 1440);
			LM_41:   return 26'((1 << 27) / 40);
			LM_42:   return 26'((1 << 27) / 720);
			LM_43:   return 26'((1 << 27) / 10080);
			LM_44:   return 26'((1 << 27) / 80640);
			default: return 26'((1 << 27) / 2);
		endcase
	endfunction

endpackage

// ===== rtl/associated_legendre_eval_unit.sv =====
// ----------------------------------------------------------------------------
// associated_legendre_eval_unit
// Fixed-point P_l^m(x), degree 0..4 (|order| up to degree) and degree 5 (order 0).
// ----------------------------------------------------------------------------
// Fully pipelined: one beat in and one beat out per cycle. The depth is set
// by the 15-step square root of 1-x^2 (five stages), the split wide products,
// two rounding shifts and the reciprocal divide for negative orders.
// Backpressure on the output stalls the whole pipe; s_tready drops only
// while a finished beat waits.
// Unsupported (degree, order) pairs return value 0 with m_tuser set.
module associated_legendre_eval_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,  // arg_x[15:0], degree[18:16], order[22:19], pad
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,  // value[23:0]
	output logic        m_tuser   // bad_args
);

	ale_pkg::pipe_t pipe_s [ale_pkg::NST];
	ale_pkg::pipe_t nxt    [ale_pkg::NST];
	logic           vld_s  [ale_pkg::NST];
	logic           en;

	assign en       = !vld_s[ale_pkg::NST-1] || m_tready;
	assign s_tready = en;
	assign m_tvalid = vld_s[ale_pkg::NST-1];
	assign m_tdata  = pipe_s[ale_pkg::NST-1].val;
	assign m_tuser  = pipe_s[ale_pkg::NST-1].bad;

	always_comb begin
		logic signed [15:0] xi;
		logic signed [16:0] xc;
		logic signed [33:0] xsq;
		logic [29:0]        sv, rs, bt;
		logic [14:0]        r;
		logic signed [32:0] xr;
		logic signed [31:0] a_op;
		logic signed [35:0] b_op;
		logic signed [68:0] psum;
		logic [71:0]        mag, t;
		logic [5:0]         sh;
		logic [67:0]        mag5;
		logic [24:0]        t5;
		logic [49:0]        av;
		logic [51:0]        pr;
		logic [42:0]        lim;
		logic signed [49:0] w;
		logic [16:0]        d;

		// s0: clamp, decode, x^2
		nxt[0] = '0;
		xi = $signed(s_tdata[15:0]);
		if (xi > 16'sd16384) begin
			xc = 17'sd16384;
		end else if (xi < -16'sd16384) begin
			xc = -17'sd16384;
		end else begin
			xc = {xi[15], xi};
		end
		nxt[0].x   = xc;
		nxt[0].l   = s_tdata[18:16];
		nxt[0].neg = s_tdata[22];
		nxt[0].am  = s_tdata[22] ? (~s_tdata[22:19] + 4'd1) : s_tdata[22:19];
		nxt[0].bad = (nxt[0].l > 3'd5) || ({1'b0, nxt[0].l} < nxt[0].am)
			|| (nxt[0].l == 3'd5 && nxt[0].am != 4'd0);
		xsq = xc * xc;
		nxt[0].u = xsq[28:0];

		// s1..s5: restoring square root of 1-x^2, three digits per stage
		for (int k = 1; k <= 5; k++) begin
			nxt[k] = pipe_s[k-1];
			if (k == 1) begin
				nxt[k].s = 29'h1000_0000 - pipe_s[0].u;
				sv = {1'b0, 29'h1000_0000 - pipe_s[0].u};
				rs = '0;
			end else begin
				sv = pipe_s[k-1].sv;
				rs = pipe_s[k-1].rs;
			end
			for (int j = 0; j < 3; j++) begin
				bt = 30'd1 << (28 - 2 * (3 * (k - 1) + j));
				if (sv >= rs + bt) begin
					sv = sv - (rs + bt);
					rs = (rs >> 1) + bt;
				end else begin
					rs = rs >> 1;
				end
			end
			nxt[k].sv = sv;
			nxt[k].rs = rs;
		end

		// s6: x*r and linear term
		nxt[6] = pipe_s[5];
		r = pipe_s[5].rs[14:0];
		xr = pipe_s[5].x * $signed({1'b0, r});
		nxt[6].tt  = xr[31:0];
		nxt[6].lin = ale_pkg::lin_of(pipe_s[5].l, pipe_s[5].am, pipe_s[5].u);

		// s7: operand select, split product
		nxt[7] = pipe_s[6];
		a_op = '0;
		b_op = '0;
		unique case ({pipe_s[6].l, pipe_s[6].am})
			ale_pkg::LM_10: begin
				a_op = {{15{pipe_s[6].x[16]}}, pipe_s[6].x};
				b_op = 36'sd1;
			end
			ale_pkg::LM_11: begin
				a_op = {17'd0, pipe_s[6].rs[14:0]};
				b_op = 36'sd1;
			end
			ale_pkg::LM_20: begin
				a_op = 32'sd1;
				b_op = pipe_s[6].lin;
			end
			ale_pkg::LM_21: begin
				a_op = pipe_s[6].tt;
				b_op = 36'sd1;
			end
			ale_pkg::LM_22: begin
				a_op = {3'd0, pipe_s[6].s};
				b_op = 36'sd1;
			end
			ale_pkg::LM_30: begin
				a_op = {{15{pipe_s[6].x[16]}}, pipe_s[6].x};
				b_op = pipe_s[6].lin;
			end
			ale_pkg::LM_31: begin
				a_op = {17'd0, pipe_s[6].rs[14:0]};
				b_op = pipe_s[6].lin;
			end
			ale_pkg::LM_32: begin
				a_op = {{15{pipe_s[6].x[16]}}, pipe_s[6].x};
				b_op = {7'd0, pipe_s[6].s};
			end
			ale_pkg::LM_33: begin
				a_op = {3'd0, pipe_s[6].s};
				b_op = {21'd0, pipe_s[6].rs[14:0]};
			end
			ale_pkg::LM_40, ale_pkg::LM_50: begin
				a_op = {3'd0, pipe_s[6].u};
				b_op = pipe_s[6].lin;
			end
			ale_pkg::LM_41: begin
				a_op = pipe_s[6].tt;
				b_op = pipe_s[6].lin;
			end
			ale_pkg::LM_42: begin
				a_op = {3'd0, pipe_s[6].s};
				b_op = pipe_s[6].lin;
			end
			ale_pkg::LM_43: begin
				a_op = pipe_s[6].tt;
				b_op = {7'd0, pipe_s[6].s};
			end
			ale_pkg::LM_44: begin
				a_op = {3'd0, pipe_s[6].s};
				b_op = {7'd0, pipe_s[6].s};
			end
			default: begin
				a_op = '0;
				b_op = '0;
			end
		endcase
		nxt[7].pl = a_op * $signed({1'b0, b_op[17:0]});
		nxt[7].ph = a_op * $signed(b_op[35:18]);

		// s8: recombine halves
		nxt[8] = pipe_s[7];
		psum = $signed({pipe_s[7].ph[49], pipe_s[7].ph, 18'd0})
			+ $signed({{18{pipe_s[7].pl[50]}}, pipe_s[7].pl});
		nxt[8].pp = psum[63:0];

		// s9: constant factor
		nxt[9] = pipe_s[8];
		nxt[9].nn = pipe_s[8].pp * ale_pkg::c_of(pipe_s[8].l, pipe_s[8].am);

		// s10: constant term
		nxt[10] = pipe_s[9];
		nxt[10].nn = pipe_s[9].nn + ale_pkg::k_of(pipe_s[9].l, pipe_s[9].am);

		// s11: magnitude plus half lsb
		nxt[11] = pipe_s[10];
		sh = ale_pkg::sh_of(pipe_s[10].l, pipe_s[10].am);
		nxt[11].nsg = pipe_s[10].nn[71];
		mag = pipe_s[10].nn[71] ? (~pipe_s[10].nn + 72'd1) : pipe_s[10].nn;
		nxt[11].mh = mag + ((sh == 6'd0) ? 72'd0 : (72'd1 << (sh - 6'd1)));

		// s12: shift, restore sign
		nxt[12] = pipe_s[11];
		t = pipe_s[11].mh >> ale_pkg::sh_of(pipe_s[11].l, pipe_s[11].am);
		nxt[12].vv = pipe_s[11].nsg ? (~t[49:0] + 50'd1) : t[49:0];

		// s13..s16: degree 5 takes x*q, rounded by 2^43
		nxt[13] = pipe_s[12];
		nxt[13].xl = pipe_s[12].x * $signed({1'b0, pipe_s[12].vv[24:0]});
		nxt[13].xh = pipe_s[12].x * $signed(pipe_s[12].vv[49:25]);

		nxt[14] = pipe_s[13];
		nxt[14].xn = $signed({pipe_s[13].xh[41], pipe_s[13].xh, 25'd0})
			+ $signed({{25{pipe_s[13].xl[42]}}, pipe_s[13].xl});

		nxt[15] = pipe_s[14];
		nxt[15].nsg = pipe_s[14].xn[67];
		mag5 = pipe_s[14].xn[67] ? (~pipe_s[14].xn + 68'd1) : pipe_s[14].xn;
		nxt[15].mh5 = mag5 + (68'd1 << 42);

		nxt[16] = pipe_s[15];
		t5 = pipe_s[15].mh5[67:43];
		if (pipe_s[15].l == 3'd5) begin
			nxt[16].vv = pipe_s[15].nsg ? (~{25'd0, t5} + 50'd1) : {25'd0, t5};
		end

		// s17..s20: rounded divide by (l+m)!/(l-m)!
		nxt[17] = pipe_s[16];
		d = ale_pkg::den_of(pipe_s[16].l, pipe_s[16].am);
		nxt[17].nsg = pipe_s[16].vv[49];
		av = pipe_s[16].vv[49] ? (~pipe_s[16].vv + 50'd1) : pipe_s[16].vv;
		nxt[17].n2 = {av[24:0], 1'b0} + {9'd0, d};

		nxt[18] = pipe_s[17];
		pr = pipe_s[17].n2 * ale_pkg::rcp_of(pipe_s[17].l, pipe_s[17].am);
		nxt[18].q0 = pr[51:27];

		nxt[19] = pipe_s[18];
		d = ale_pkg::den_of(pipe_s[18].l, pipe_s[18].am);
		nxt[19].qd = pipe_s[18].q0 * {d, 1'b0};

		nxt[20] = pipe_s[19];
		d = ale_pkg::den_of(pipe_s[19].l, pipe_s[19].am);
		lim = pipe_s[19].qd + {25'd0, d, 1'b0};
		nxt[20].qq = ({17'd0, pipe_s[19].n2} >= lim) ? (pipe_s[19].q0 + 25'd1)
			: pipe_s[19].q0;

		// s21: sign, saturate, error gate
		nxt[21] = pipe_s[20];
		if (pipe_s[20].neg) begin
			w = $signed({25'd0, pipe_s[20].qq});
			if (pipe_s[20].nsg ^ pipe_s[20].am[0]) begin
				w = -w;
			end
		end else begin
			w = pipe_s[20].vv;
		end
		if (pipe_s[20].bad) begin
			nxt[21].val = '0;
		end else if (w > 50'sd8388607) begin
			nxt[21].val = 24'h7F_FFFF;
		end else if (w < -50'sd8388608) begin
			nxt[21].val = 24'h80_0000;
		end else begin
			nxt[21].val = w[23:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < ale_pkg::NST; k++) begin
				vld_s[k] <= 1'b0;
			end
		end else if (en) begin
			vld_s[0] <= s_tvalid;
			for (int k = 1; k < ale_pkg::NST; k++) begin
				vld_s[k] <= vld_s[k-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < ale_pkg::NST; k++) begin
				pipe_s[k] <= nxt[k];
			end
		end
	end

	a_bad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tdata == 24'd0)
		else $error("bad_args beat with nonzero value");

	a_stall_only: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> m_tvalid && !m_tready)
		else $error("input stalled without output backpressure");

	a_sqrt_range: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s[5] |-> pipe_s[5].rs <= 30'd16384)
		else $error("square root out of range");

	a_div_corr: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s[19] && pipe_s[19].neg && !pipe_s[19].bad |-> pipe_s[19].qd <= {17'd0, pipe_s[19].n2})
		else $error("reciprocal estimate too large");

endmodule
